FILE: hdl/hsfs_pkg.sv
package hsfs_pkg;

    localparam int DEF_MAX_CODE_BITS = 32;

    // syntax steps of the parameter set walk
    localparam logic [4:0] ST_HEAD         = 5'd0;
    localparam logic [4:0] ST_CONSTR       = 5'd1;
    localparam logic [4:0] ST_SPS_ID       = 5'd2;
    localparam logic [4:0] ST_CHROMA       = 5'd3;
    localparam logic [4:0] ST_SEP_PLANE    = 5'd4;
    localparam logic [4:0] ST_LUMA_DEPTH   = 5'd5;
    localparam logic [4:0] ST_CHROMA_DEPTH = 5'd6;
    localparam logic [4:0] ST_BYPASS       = 5'd7;
    localparam logic [4:0] ST_MATRIX       = 5'd8;
    localparam logic [4:0] ST_LIST_FLAG    = 5'd9;
    localparam logic [4:0] ST_DELTA        = 5'd10;
    localparam logic [4:0] ST_LOG2_FN      = 5'd11;
    localparam logic [4:0] ST_POC_TYPE     = 5'd12;
    localparam logic [4:0] ST_POC_LSB      = 5'd13;
    localparam logic [4:0] ST_DELTA_ZERO   = 5'd14;
    localparam logic [4:0] ST_NON_REF      = 5'd15;
    localparam logic [4:0] ST_TOP_BOT      = 5'd16;
    localparam logic [4:0] ST_NUM_OFFS     = 5'd17;
    localparam logic [4:0] ST_OFFSET       = 5'd18;
    localparam logic [4:0] ST_NUM_REF      = 5'd19;
    localparam logic [4:0] ST_GAPS         = 5'd20;
    localparam logic [4:0] ST_WIDTH        = 5'd21;
    localparam logic [4:0] ST_HEIGHT       = 5'd22;
    localparam logic [4:0] ST_FRAME_ONLY   = 5'd23;
    localparam logic [4:0] ST_MBAFF        = 5'd24;
    localparam logic [4:0] ST_DIRECT       = 5'd25;
    localparam logic [4:0] ST_CROP_FLAG    = 5'd26;
    localparam logic [4:0] ST_CROP_L       = 5'd27;
    localparam logic [4:0] ST_CROP_R       = 5'd28;
    localparam logic [4:0] ST_CROP_T       = 5'd29;
    localparam logic [4:0] ST_CROP_B       = 5'd30;
    localparam logic [4:0] ST_IDLE         = 5'd31;

    localparam logic [4:0] HEAD_BITS   = 5'd16;
    localparam logic [3:0] NUM_LISTS   = 4'd8;
    localparam logic [3:0] SMALL_LISTS = 4'd6;
    localparam logic [6:0] SMALL_SIZE  = 7'd16;
    localparam logic [6:0] BIG_SIZE    = 7'd64;
    localparam logic [7:0] SCALE_INIT  = 8'd8;

    typedef struct packed {
        logic [4:0]  step;
        logic [4:0]  skip_left;
        logic [5:0]  zero_run;
        logic [31:0] code_bits;
        logic [5:0]  suffix_left;
        logic [7:0]  profile_seen;
        logic [3:0]  list_index;
        logic [6:0]  list_count;
        logic [7:0]  held_scale;
        logic [7:0]  trial_scale;
        logic [31:0] ref_offsets_left;
        logic [31:0] width_mbs;
        logic [31:0] height_units;
        logic        frame_only;
        logic [31:0] crop_sum_x;
        logic [31:0] crop_sum_y;
        logic        result_sent;
        logic        hit;
        logic        hit_ok;
    } parse_state_t;

    typedef struct packed {
        logic        ok;
        logic        frame_only;
        logic [31:0] width_mbs;
        logic [31:0] height_units;
        logic [31:0] crop_sum_x;
        logic [31:0] crop_sum_y;
    } size_evt_t;

    localparam parse_state_t PARSE_RESET = '{
        step: ST_HEAD, skip_left: '0, zero_run: '0, code_bits: '0,
        suffix_left: '0, profile_seen: '0, list_index: '0, list_count: '0,
        held_scale: SCALE_INIT, trial_scale: SCALE_INIT, ref_offsets_left: '0,
        width_mbs: '0, height_units: '0, frame_only: 1'b0, crop_sum_x: '0,
        crop_sum_y: '0, result_sent: 1'b0, hit: 1'b0, hit_ok: 1'b0};

    function automatic logic high_profile(logic [7:0] p);
        return p == 8'd100 || p == 8'd110 || p == 8'd122 || p == 8'd144 ||
               p == 8'd244 || p == 8'd44 || p == 8'd83 || p == 8'd86 ||
               p == 8'd118 || p == 8'd128 || p == 8'd138 || p == 8'd139 ||
               p == 8'd134;
    endfunction

    function automatic logic step_is_code(logic [4:0] s);
        logic r;
        unique case (s)
            ST_SPS_ID, ST_CHROMA, ST_LUMA_DEPTH, ST_CHROMA_DEPTH, ST_DELTA,
            ST_LOG2_FN, ST_POC_TYPE, ST_POC_LSB, ST_NON_REF, ST_TOP_BOT,
            ST_NUM_OFFS, ST_OFFSET, ST_NUM_REF, ST_WIDTH, ST_HEIGHT,
            ST_CROP_L, ST_CROP_R, ST_CROP_T, ST_CROP_B: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic parse_state_t emit(parse_state_t s, logic ok);
        parse_state_t n;
        n = s;
        n.hit = 1'b1;
        n.hit_ok = ok;
        n.result_sent = 1'b1;
        n.step = ST_IDLE;
        return n;
    endfunction

    function automatic parse_state_t next_list(parse_state_t s);
        parse_state_t n;
        n = s;
        n.list_index = s.list_index + 4'd1;
        n.step = (n.list_index >= NUM_LISTS) ? ST_LOG2_FN : ST_LIST_FLAG;
        return n;
    endfunction

    function automatic parse_state_t code_done(parse_state_t s, logic [31:0] v);
        parse_state_t n;
        logic [7:0]   half;
        logic [7:0]   delta;
        logic [7:0]   nxt;
        logic [6:0]   size;
        logic [31:0]  v2;
        logic [31:0]  v4;
        n = s;
        n.zero_run = '0;
        n.code_bits = '0;
        n.suffix_left = '0;
        half = v[8:1];
        delta = v[0] ? half + 8'd1 : 8'd0 - half;
        nxt = s.held_scale + delta;
        size = (s.list_index < SMALL_LISTS) ? SMALL_SIZE : BIG_SIZE;
        v2 = {v[30:0], 1'b0};
        v4 = {v[29:0], 2'b00};
        unique case (s.step)
            ST_SPS_ID:       n.step = high_profile(s.profile_seen) ? ST_CHROMA : ST_LOG2_FN;
            ST_CHROMA:       n.step = (v == 32'd3) ? ST_SEP_PLANE : ST_LUMA_DEPTH;
            ST_LUMA_DEPTH:   n.step = ST_CHROMA_DEPTH;
            ST_CHROMA_DEPTH: n.step = ST_BYPASS;
            ST_DELTA:
            begin
                n.trial_scale = nxt;
                if (nxt != 8'd0)
                begin
                    n.held_scale = nxt;
                end
                n.list_count = s.list_count + 7'd1;
                if (nxt == 8'd0 || n.list_count >= size)
                begin
                    n = next_list(n);
                end
            end
            ST_LOG2_FN:      n.step = ST_POC_TYPE;
            ST_POC_TYPE:
                n.step = (v == 32'd0) ? ST_POC_LSB :
                         (v == 32'd1) ? ST_DELTA_ZERO : ST_NUM_REF;
            ST_POC_LSB:      n.step = ST_NUM_REF;
            ST_NON_REF:      n.step = ST_TOP_BOT;
            ST_TOP_BOT:      n.step = ST_NUM_OFFS;
            ST_NUM_OFFS:
            begin
                n.ref_offsets_left = v;
                n.step = (v == 32'd0) ? ST_NUM_REF : ST_OFFSET;
            end
            ST_OFFSET:
            begin
                n.ref_offsets_left = s.ref_offsets_left - 32'd1;
                if (n.ref_offsets_left == 32'd0)
                begin
                    n.step = ST_NUM_REF;
                end
            end
            ST_NUM_REF:      n.step = ST_GAPS;
            ST_WIDTH:
            begin
                n.width_mbs = v + 32'd1;
                n.step = ST_HEIGHT;
            end
            ST_HEIGHT:
            begin
                n.height_units = v + 32'd1;
                n.step = ST_FRAME_ONLY;
            end
            ST_CROP_L:
            begin
                n.crop_sum_x = s.crop_sum_x + v2;
                n.step = ST_CROP_R;
            end
            ST_CROP_R:
            begin
                n.crop_sum_x = s.crop_sum_x + v2;
                n.step = ST_CROP_T;
            end
            ST_CROP_T:
            begin
                n.crop_sum_y = s.crop_sum_y + (s.frame_only ? v2 : v4);
                n.step = ST_CROP_B;
            end
            ST_CROP_B:
            begin
                n.crop_sum_y = s.crop_sum_y + (s.frame_only ? v2 : v4);
                n = emit(n, 1'b1);
            end
            default:         n.step = ST_IDLE;
        endcase
        return n;
    endfunction

    // one bit of the stream, msb first
    function automatic parse_state_t bit_step(parse_state_t s, logic b,
                                              logic [5:0] zr_limit);
        parse_state_t n;
        logic [31:0]  cb;
        logic [31:0]  v;
        n = s;
        cb = {s.code_bits[30:0], b};
        v = (32'd1 << s.zero_run[4:0]) + cb - 32'd1;
        if (s.step == ST_IDLE)
        begin
            n = s;
        end
        else if (step_is_code(s.step))
        begin
            if (s.suffix_left == 6'd0)
            begin
                if (!b)
                begin
                    if (s.zero_run >= zr_limit)
                    begin
                        n = emit(s, 1'b0);
                    end
                    else
                    begin
                        n.zero_run = s.zero_run + 6'd1;
                    end
                end
                else if (s.zero_run == 6'd0)
                begin
                    n = code_done(s, 32'd0);
                end
                else
                begin
                    n.suffix_left = s.zero_run;
                    n.code_bits = '0;
                end
            end
            else
            begin
                n.code_bits = cb;
                n.suffix_left = s.suffix_left - 6'd1;
                if (n.suffix_left == 6'd0)
                begin
                    n = code_done(n, v);
                end
            end
        end
        else
        begin
            unique case (s.step)
                ST_HEAD:
                begin
                    n.code_bits = cb;
                    n.skip_left = s.skip_left + 5'd1;
                    if (n.skip_left >= HEAD_BITS)
                    begin
                        n.profile_seen = cb[7:0];
                        n.code_bits = '0;
                        n.skip_left = '0;
                        n.step = ST_CONSTR;
                    end
                end
                ST_CONSTR:
                begin
                    n.skip_left = s.skip_left + 5'd1;
                    if (n.skip_left >= HEAD_BITS)
                    begin
                        n.skip_left = '0;
                        n.step = ST_SPS_ID;
                    end
                end
                ST_SEP_PLANE:  n.step = ST_LUMA_DEPTH;
                ST_BYPASS:     n.step = ST_MATRIX;
                ST_MATRIX:
                begin
                    n.list_index = '0;
                    n.step = b ? ST_LIST_FLAG : ST_LOG2_FN;
                end
                ST_LIST_FLAG:
                begin
                    if (b)
                    begin
                        n.list_count = '0;
                        n.held_scale = SCALE_INIT;
                        n.trial_scale = SCALE_INIT;
                        n.step = ST_DELTA;
                    end
                    else
                    begin
                        n = next_list(s);
                    end
                end
                ST_DELTA_ZERO: n.step = ST_NON_REF;
                ST_GAPS:       n.step = ST_WIDTH;
                ST_FRAME_ONLY:
                begin
                    n.frame_only = b;
                    n.step = b ? ST_DIRECT : ST_MBAFF;
                end
                ST_MBAFF:      n.step = ST_DIRECT;
                ST_DIRECT:     n.step = ST_CROP_FLAG;
                ST_CROP_FLAG:
                begin
                    if (b)
                    begin
                        n.step = ST_CROP_L;
                    end
                    else
                    begin
                        n = emit(s, 1'b1);
                    end
                end
                default:       n.step = ST_IDLE;
            endcase
        end
        return n;
    endfunction

endpackage

FILE: hdl/hsfs_in_if.sv
interface hsfs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink (input valid, input data_byte, input last, output ready);
endinterface

FILE: hdl/hsfs_out_if.sv
interface hsfs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] frame_width;
    logic [31:0] frame_height;
    logic        ok;

    modport source (output valid, output frame_width, output frame_height, output ok,
                    input ready);
    modport sink (input valid, input frame_width, input frame_height, input ok,
                  output ready);
endinterface

FILE: hdl/hsfs_byte_parser.sv
module hsfs_byte_parser
    import hsfs_pkg::*;
#(
    parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    hsfs_in_if.sink    in_ch,
    input  logic       evt_take,
    output logic       evt_valid,
    output size_evt_t  evt
);

    localparam logic [5:0] ZR_LIMIT = 6'(MAX_CODE_BITS - 1);

    parse_state_t state_reg, state_next, walk;
    logic         evt_valid_reg, evt_valid_next;
    size_evt_t    evt_reg, evt_next;
    logic         accept;

    assign in_ch.ready = !evt_valid_reg || evt_take;
    assign accept = in_ch.valid && in_ch.ready;

    always_comb
    begin
        walk = state_reg;
        walk.hit = 1'b0;
        walk.hit_ok = 1'b0;
        for (int i = 7; i >= 0; i--)
        begin
            walk = bit_step(walk, in_ch.data_byte[i], ZR_LIMIT);
        end
        // end of set with no result yet: valid only inside the crop codes
        if (in_ch.last && !walk.result_sent)
        begin
            walk = emit(walk, walk.step >= ST_CROP_L && walk.step <= ST_CROP_B);
        end
        state_next = in_ch.last ? PARSE_RESET : walk;
        evt_next.ok = walk.hit_ok;
        evt_next.frame_only = walk.frame_only;
        evt_next.width_mbs = walk.width_mbs;
        evt_next.height_units = walk.height_units;
        evt_next.crop_sum_x = walk.crop_sum_x;
        evt_next.crop_sum_y = walk.crop_sum_y;
        evt_valid_next = evt_valid_reg && !evt_take;
        if (accept && walk.hit)
        begin
            evt_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PARSE_RESET;
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
            end
            evt_valid_reg <= evt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && walk.hit)
        begin
            evt_reg <= evt_next;
        end
    end

    assign evt_valid = evt_valid_reg;
    assign evt = evt_reg;

    a_evt_held: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid_reg && !evt_take |=> evt_valid_reg)
        else $error("pending size event dropped");

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_ch.last |=> state_reg.step == ST_HEAD && !state_reg.result_sent)
        else $error("parser not back at header after last byte");

    a_idle_sent: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.step == ST_IDLE |-> state_reg.result_sent)
        else $error("parser idle without a result");

    a_one_per_set: assert property (@(posedge clk) disable iff (!rst_n)
        accept && state_reg.result_sent |-> !walk.hit)
        else $error("second result in one set");

endmodule

FILE: hdl/hsfs_result_stage.sv
module hsfs_result_stage
    import hsfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       evt_valid,
    input  size_evt_t  evt,
    output logic       evt_take,
    hsfs_out_if.source out_ch
);

    logic        out_valid_reg;
    logic [31:0] width_reg, width_next;
    logic [31:0] height_reg, height_next;
    logic        ok_reg;
    logic [31:0] h_base;

    assign evt_take = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        h_base = {evt.height_units[27:0], 4'b0000} - evt.crop_sum_y;
        width_next = '0;
        height_next = '0;
        if (evt.ok)
        begin
            width_next = {evt.width_mbs[27:0], 4'b0000} - evt.crop_sum_x;
            height_next = evt.frame_only ? h_base : {h_base[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (evt_take)
        begin
            out_valid_reg <= evt_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_take && evt_valid)
        begin
            width_reg <= width_next;
            height_reg <= height_next;
            ok_reg <= evt.ok;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.frame_width = width_reg;
    assign out_ch.frame_height = height_reg;
    assign out_ch.ok = ok_reg;

endmodule

FILE: hdl/h264_sps_frame_size_parser_core.sv
// channel   dir  payload                            transaction
// in_ch     in   data_byte[7:0], last                one sps byte
// out_ch    out  frame_width[31:0], frame_height[31:0], ok   one size report
//
// one byte is taken every cycle unless the input stalls; all eight bit steps of the parser are
// unrolled between the parser state register and the event register
// a size report passes from the byte that completes it through the event
// register, then the result register that forms width and height
// rst_n clears the parser to the header byte and empties both stages
// a stalled output holds its report; input stalls only when both stages are full
module h264_sps_frame_size_parser_core
    import hsfs_pkg::*;
#(
    parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    hsfs_in_if.sink    in_ch,
    hsfs_out_if.source out_ch
);

    // event handoff between the bit walker and the size arithmetic
    logic      evt_valid;
    logic      evt_take;
    size_evt_t evt;

    // bit walker: exp-golomb decode, scaling lists, poc and crop fields
    hsfs_byte_parser #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .evt_take  (evt_take),
        .evt_valid (evt_valid),
        .evt       (evt)
    );

    // size arithmetic and output register
    hsfs_result_stage u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt       (evt),
        .evt_take  (evt_take),
        .out_ch    (out_ch)
    );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import hsfs_pkg::*;

    typedef struct {
        logic [31:0] w;
        logic [31:0] h;
        logic        ok;
    } size_rep_t;

    // predicts the size report of each parameter set, one byte at a time,
    // and checks the reports that leave the block against that prediction
    class size_scoreboard;
        logic [4:0]  step;
        int unsigned skip_cnt;
        int unsigned zeros;
        logic [31:0] suffix;
        int unsigned suffix_cnt;
        logic [7:0]  profile;
        int unsigned list_idx;
        int unsigned list_cnt;
        logic [7:0]  held_scale;
        logic [7:0]  trial_scale;
        logic [31:0] offs_left;
        logic [31:0] width_mbs;
        logic [31:0] height_units;
        logic        frame_only;
        logic [31:0] crop_x;
        logic [31:0] crop_y;
        logic        sent;
        int          max_zeros;
        size_rep_t   pending[$];
        int          mismatches;
        int          sets;
        int          good_reports;
        int          bad_reports;

        function new(int max_bits);
            max_zeros = max_bits - 1;
            mismatches = 0;
            sets = 0;
            good_reports = 0;
            bad_reports = 0;
            clear();
        endfunction

        function void clear();
            step = ST_HEAD;
            skip_cnt = 0;
            zeros = 0;
            suffix = '0;
            suffix_cnt = 0;
            profile = '0;
            list_idx = 0;
            list_cnt = 0;
            held_scale = 8'd8;
            trial_scale = 8'd8;
            offs_left = '0;
            width_mbs = '0;
            height_units = '0;
            frame_only = 1'b0;
            crop_x = '0;
            crop_y = '0;
            sent = 1'b0;
        endfunction

        function bit is_code_step(logic [4:0] s);
            case (s)
                ST_SPS_ID, ST_CHROMA, ST_LUMA_DEPTH, ST_CHROMA_DEPTH, ST_DELTA,
                ST_LOG2_FN, ST_POC_TYPE, ST_POC_LSB, ST_NON_REF, ST_TOP_BOT,
                ST_NUM_OFFS, ST_OFFSET, ST_NUM_REF, ST_WIDTH, ST_HEIGHT,
                ST_CROP_L, ST_CROP_R, ST_CROP_T, ST_CROP_B: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function void report(bit good);
            size_rep_t r;
            logic [31:0] hgt;
            hgt = height_units * 32'd16 - crop_y;
            if (good)
            begin
                r.w = width_mbs * 32'd16 - crop_x;
                r.h = frame_only ? hgt : hgt * 32'd2;
                r.ok = 1'b1;
                good_reports++;
            end
            else
            begin
                r.w = '0;
                r.h = '0;
                r.ok = 1'b0;
                bad_reports++;
            end
            pending.push_back(r);
            sent = 1'b1;
            step = ST_IDLE;
        endfunction

        function void advance_list();
            list_idx++;
            step = (list_idx >= 8) ? ST_LOG2_FN : ST_LIST_FLAG;
        endfunction

        function void code_done(logic [31:0] v);
            logic [7:0]  half;
            logic [7:0]  delta;
            int unsigned lsize;
            zeros = 0;
            suffix = '0;
            suffix_cnt = 0;
            case (step)
                ST_SPS_ID:
                    step = (profile inside {100, 110, 122, 144, 244, 44, 83, 86,
                                            118, 128, 138, 139, 134})
                           ? ST_CHROMA : ST_LOG2_FN;
                ST_CHROMA:       step = (v == 32'd3) ? ST_SEP_PLANE : ST_LUMA_DEPTH;
                ST_LUMA_DEPTH:   step = ST_CHROMA_DEPTH;
                ST_CHROMA_DEPTH: step = ST_BYPASS;
                ST_DELTA:
                begin
                    half = v[8:1];
                    delta = v[0] ? half + 8'd1 : 8'd0 - half;
                    lsize = (list_idx < 6) ? 16 : 64;
                    trial_scale = held_scale + delta;
                    if (trial_scale != 8'd0)
                        held_scale = trial_scale;
                    list_cnt++;
                    if (trial_scale == 8'd0 || list_cnt >= lsize)
                        advance_list();
                end
                ST_LOG2_FN:      step = ST_POC_TYPE;
                ST_POC_TYPE:
                    step = (v == 32'd0) ? ST_POC_LSB :
                           (v == 32'd1) ? ST_DELTA_ZERO : ST_NUM_REF;
                ST_POC_LSB:      step = ST_NUM_REF;
                ST_NON_REF:      step = ST_TOP_BOT;
                ST_TOP_BOT:      step = ST_NUM_OFFS;
                ST_NUM_OFFS:
                begin
                    offs_left = v;
                    step = (v == 32'd0) ? ST_NUM_REF : ST_OFFSET;
                end
                ST_OFFSET:
                begin
                    offs_left = offs_left - 32'd1;
                    if (offs_left == 32'd0)
                        step = ST_NUM_REF;
                end
                ST_NUM_REF:      step = ST_GAPS;
                ST_WIDTH:
                begin
                    width_mbs = v + 32'd1;
                    step = ST_HEIGHT;
                end
                ST_HEIGHT:
                begin
                    height_units = v + 32'd1;
                    step = ST_FRAME_ONLY;
                end
                ST_CROP_L:
                begin
                    crop_x = crop_x + v * 32'd2;
                    step = ST_CROP_R;
                end
                ST_CROP_R:
                begin
                    crop_x = crop_x + v * 32'd2;
                    step = ST_CROP_T;
                end
                ST_CROP_T:
                begin
                    crop_y = crop_y + (frame_only ? v * 32'd2 : v * 32'd4);
                    step = ST_CROP_B;
                end
                ST_CROP_B:
                begin
                    crop_y = crop_y + (frame_only ? v * 32'd2 : v * 32'd4);
                    report(1'b1);
                end
                default:         step = ST_IDLE;
            endcase
        endfunction

        function void take_bit(bit b);
            if (step == ST_IDLE)
                return;
            if (is_code_step(step))
            begin
                if (suffix_cnt == 0)
                begin
                    if (!b)
                    begin
                        if (zeros >= max_zeros)
                            report(1'b0);
                        else
                            zeros++;
                    end
                    else if (zeros == 0)
                        code_done(32'd0);
                    else
                    begin
                        suffix_cnt = zeros;
                        suffix = '0;
                    end
                end
                else
                begin
                    suffix = {suffix[30:0], b};
                    suffix_cnt--;
                    if (suffix_cnt == 0)
                        code_done((32'd1 << zeros) + suffix - 32'd1);
                end
                return;
            end
            case (step)
                ST_HEAD:
                begin
                    suffix = {suffix[30:0], b};
                    skip_cnt++;
                    if (skip_cnt >= 16)
                    begin
                        profile = suffix[7:0];
                        suffix = '0;
                        skip_cnt = 0;
                        step = ST_CONSTR;
                    end
                end
                ST_CONSTR:
                begin
                    skip_cnt++;
                    if (skip_cnt >= 16)
                    begin
                        skip_cnt = 0;
                        step = ST_SPS_ID;
                    end
                end
                ST_SEP_PLANE:  step = ST_LUMA_DEPTH;
                ST_BYPASS:     step = ST_MATRIX;
                ST_MATRIX:
                begin
                    list_idx = 0;
                    step = b ? ST_LIST_FLAG : ST_LOG2_FN;
                end
                ST_LIST_FLAG:
                begin
                    if (b)
                    begin
                        list_cnt = 0;
                        held_scale = 8'd8;
                        trial_scale = 8'd8;
                        step = ST_DELTA;
                    end
                    else
                        advance_list();
                end
                ST_DELTA_ZERO: step = ST_NON_REF;
                ST_GAPS:       step = ST_WIDTH;
                ST_FRAME_ONLY:
                begin
                    frame_only = b;
                    step = b ? ST_DIRECT : ST_MBAFF;
                end
                ST_MBAFF:      step = ST_DIRECT;
                ST_DIRECT:     step = ST_CROP_FLAG;
                ST_CROP_FLAG:
                begin
                    if (b)
                        step = ST_CROP_L;
                    else
                        report(1'b1);
                end
                default:       step = ST_IDLE;
            endcase
        endfunction

        // accepted input transaction
        function void note_byte(logic [7:0] d, logic lst);
            for (int i = 7; i >= 0; i--)
                take_bit(d[i]);
            if (lst)
            begin
                if (!sent)
                    report(step >= ST_CROP_L && step <= ST_CROP_B);
                clear();
                sets++;
            end
        endfunction

        // accepted output transaction
        function void check_report(logic [31:0] w, logic [31:0] h, logic ok);
            size_rep_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected report w=%0d h=%0d ok=%0b", w, h, ok);
                return;
            end
            e = pending.pop_front();
            if (w !== e.w || h !== e.h || ok !== e.ok)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("report mismatch: exp w=%0d h=%0d ok=%0b, got w=%0d h=%0d ok=%0b",
                             e.w, e.h, e.ok, w, h, ok);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    hsfs_in_if  in_ch ();
    hsfs_out_if out_ch ();

    h264_sps_frame_size_parser_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    size_scoreboard sb;
    bit             bitq[$];   // bits of the set under construction, msb first
    logic [7:0]     byteq[$];  // bytes of that set
    int             sent_bytes;
    bit             stim_done;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // monitors: every handshake is seen at the edge that completes it
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.note_byte(in_ch.data_byte, in_ch.last);
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_report(out_ch.frame_width, out_ch.frame_height, out_ch.ok);
    end

    // gap length: mostly none, sometimes short, rarely long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // output side stalls at random, with quiet stretches in between
    initial
    begin
        int n;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = pick_gap();
            if (n > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(30, 1)) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // bit stream construction
    // ------------------------------------------------------------------
    function automatic void put_bits(logic [31:0] v, int n);
        for (int i = n - 1; i >= 0; i--)
            bitq.push_back(v[i]);
    endfunction

    // unsigned exp-golomb
    function automatic void put_ue(logic [31:0] v);
        logic [32:0] c;
        int          nb;
        c = {1'b0, v} + 33'd1;
        nb = 0;
        for (int i = 0; i < 33; i++)
            if (c[i])
                nb = i;
        for (int i = 0; i < nb; i++)
            bitq.push_back(1'b0);
        for (int i = nb; i >= 0; i--)
            bitq.push_back(c[i]);
    endfunction

    // signed exp-golomb
    function automatic void put_se(int k);
        if (k > 0)
            put_ue(2 * k - 1);
        else
            put_ue(-2 * k);
    endfunction

    // code values: mostly small, a few up to the largest 32-bit code
    function automatic logic [31:0] pick_val();
        int r;
        logic [31:0] v;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(3);
        if (r < 90)
            return $urandom_range(300);
        v = $urandom();
        return (v == 32'hFFFF_FFFF) ? 32'hFFFF_FFFE : v;
    endfunction

    function automatic void put_scaling_lists();
        int          lsize;
        int          d;
        logic [7:0]  last_s;
        logic [7:0]  nxt;
        for (int li = 0; li < 8; li++)
        begin
            if ($urandom_range(1))
            begin
                bitq.push_back(1'b1);
                lsize = (li < 6) ? 16 : 64;
                last_s = 8'd8;
                for (int j = 0; j < lsize; j++)
                begin
                    if ($urandom_range(19) == 0)
                        d = -int'(last_s);          // ends the list early
                    else if ($urandom_range(9) == 0)
                        d = $urandom_range(255) - 128;
                    else
                        d = $urandom_range(16) - 8;
                    put_se(d);
                    nxt = last_s + 8'(d);
                    if (nxt == 8'd0)
                        break;
                    last_s = nxt;
                end
            end
            else
                bitq.push_back(1'b0);
        end
    endfunction

    // a complete set; field values random but the structure well formed
    function automatic void build_set(logic [7:0] prof, bit long_code);
        logic [7:0] highs[13];
        logic [31:0] pt;
        logic [31:0] chroma;
        int          nofs;
        highs = '{100, 110, 122, 144, 244, 44, 83, 86, 118, 128, 138, 139, 134};
        bitq.delete();
        put_bits($urandom_range(255), 8);
        if (prof == 8'd0)
            prof = $urandom_range(1) ? highs[$urandom_range(12)] : 8'($urandom_range(255));
        put_bits(prof, 8);
        put_bits($urandom_range(16'hFFFF), 16);
        if (long_code)
        begin
            // a code that never ends within the allowed number of zeros
            repeat ($urandom_range(48, 32)) bitq.push_back(1'b0);
            put_bits($urandom(), 32);
            return;
        end
        put_ue($urandom_range(31));
        if (prof inside {100, 110, 122, 144, 244, 44, 83, 86, 118, 128, 138, 139, 134})
        begin
            chroma = $urandom_range(1) ? 32'd3 : 32'($urandom_range(3));
            put_ue(chroma);
            // separate plane flag only follows chroma format 3
            if (chroma == 32'd3)
                bitq.push_back($urandom_range(1));
            put_ue($urandom_range(6));
            put_ue($urandom_range(6));
            bitq.push_back($urandom_range(1));
            if ($urandom_range(1))
            begin
                bitq.push_back(1'b1);
                put_scaling_lists();
            end
            else
                bitq.push_back(1'b0);
        end
        put_ue($urandom_range(12));
        pt = ($urandom_range(9) == 0) ? 32'($urandom_range(5, 2)) : 32'($urandom_range(1));
        put_ue(pt);
        if (pt == 32'd0)
            put_ue($urandom_range(12));
        else if (pt == 32'd1)
        begin
            bitq.push_back($urandom_range(1));
            put_se($urandom_range(200) - 100);
            put_se($urandom_range(200) - 100);
            nofs = $urandom_range(4);
            put_ue(nofs);
            repeat (nofs) put_se($urandom_range(200) - 100);
        end
        put_ue($urandom_range(16));
        bitq.push_back($urandom_range(1));
        put_ue(pick_val());
        put_ue(pick_val());
        if ($urandom_range(1))
            bitq.push_back(1'b1);
        else
        begin
            bitq.push_back(1'b0);
            bitq.push_back($urandom_range(1));
        end
        bitq.push_back($urandom_range(1));
        if ($urandom_range(2) == 0)
            bitq.push_back(1'b0);
        else
        begin
            bitq.push_back(1'b1);
            repeat (4) put_ue(pick_val());
        end
    endfunction

    // pads to whole bytes with random bits plus up to two random trailing bytes
    function automatic void pack_bytes();
        logic [7:0] b;
        while (bitq.size() % 8 != 0)
            bitq.push_back($urandom_range(1));
        repeat ($urandom_range(2) * 8) bitq.push_back($urandom_range(1));
        byteq.delete();
        while (bitq.size() > 0)
        begin
            for (int i = 7; i >= 0; i--)
                b[i] = bitq.pop_front();
            byteq.push_back(b);
        end
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_byte(logic [7:0] d, logic lst);
        int n;
        n = pick_gap();
        if (n > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= d;
        in_ch.last <= lst;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sent_bytes++;
    endtask

    task automatic send_set();
        for (int i = 0; i < byteq.size(); i++)
            send_byte(byteq[i], i == byteq.size() - 1);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int kind;
        int cut;
        sb = new(DEF_MAX_CODE_BITS);
        sent_bytes = 0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: baseline set without cropping, frame coded
        bitq.delete();
        put_bits(8'h67, 8);
        put_bits(8'd66, 8);
        put_bits(16'h00FF, 16);
        put_ue(0); put_ue(0); put_ue(0); put_ue(0); put_ue(1);
        bitq.push_back(1'b0);
        put_ue(19); put_ue(14);
        bitq.push_back(1'b1); bitq.push_back(1'b1); bitq.push_back(1'b0);
        pack_bytes();
        send_set();
        // directed: set that ends right on the header byte
        send_byte(8'hFF, 1'b1);
        // directed: field coding with left and right crop codes, ending inside the crop codes
        bitq.delete();
        put_bits(8'h00, 8);
        put_bits(8'd77, 8);
        put_bits(16'hFFFF, 16);
        put_ue(0); put_ue(0); put_ue(2); put_ue(1);
        bitq.push_back(1'b0);
        put_ue(32'hFFFF_FFFE); put_ue(0);
        bitq.push_back(1'b0); bitq.push_back(1'b0); bitq.push_back(1'b0);
        bitq.push_back(1'b1);
        put_ue(1); put_ue(2);
        pack_bytes();
        send_set();
        // directed: high profile with a long code
        build_set(8'd100, 1'b1);
        pack_bytes();
        send_set();

        // hold the input until every report is out
        wait_drained();

        // random sets: mostly well formed, some cut short, some broken, some noise
        while (sent_bytes < 2000)
        begin
            kind = $urandom_range(99);
            if (kind < 90)
            begin
                build_set(8'd0, kind >= 82);
                pack_bytes();
                if (kind >= 72 && kind < 82 && byteq.size() > 1)
                begin
                    cut = $urandom_range(byteq.size() - 1, 1);
                    while (byteq.size() > cut)
                        void'(byteq.pop_back());
                end
            end
            else
            begin
                byteq.delete();
                repeat ($urandom_range(12, 1)) byteq.push_back($urandom_range(255));
            end
            send_set();
        end
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("%0d bytes in %0d parameter sets, %0d size reports and %0d error reports",
                 sent_bytes, sb.sets, sb.good_reports, sb.bad_reports);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // run limit
    initial
    begin
        #8_000_000;
        $display("timeout with %0d reports outstanding", sb.pending.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
